>>> src/afr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types and constants for the API frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam logic [7:0] DELIM  = 8'h7E;
    localparam logic [7:0] SUM_OK = 8'hFF;

    localparam logic [1:0] EV_DATA    = 2'd0;
    localparam logic [1:0] EV_GOOD    = 2'd1;
    localparam logic [1:0] EV_BAD     = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [1:0]  event_res;
        logic [7:0]  data;
        logic [15:0] byte_index;
        logic        is_last;
    } afr_res_t;

endpackage
`default_nettype wire

>>> src/api_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// api_frame_receiver
// Byte-stream receiver for delimited API frames with length and checksum.
// ----------------------------------------------------------------------------
// Path: an accepted byte's result is presented on m_tvalid from the output
//   register (parse logic between the input register and the output register).
// Throughput: one byte per cycle, limited only by the output register.
// The input register takes one more byte while a result waits downstream.
// Reset (aresetn low, synchronous): hunt for a delimiter, clear counters,
//   sum and both valid flags, and set search_limit back to 255.
// ----------------------------------------------------------------------------
module api_frame_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration: search_limit
    input  wire logic        cfg_valid,
    output wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,

    // Received bytes
    input  wire logic        s_tvalid,
    output wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte

    // Results
    output wire logic        m_tvalid,
    input  wire logic        m_tready,
    output wire logic [23:0] m_tdata,   // [7:0] data, [23:8] byte_index
    output wire logic [1:0]  m_tuser,   // [1:0] event_res
    output wire logic        m_tlast    // is_last
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic [7:0]        limit_reg;
    logic              out_valid_reg;
    logic [23:0]       out_tdata_reg;
    logic [1:0]        out_tuser_reg;
    logic              out_tlast_reg;

    logic              out_free;
    logic              step_en;
    afr_pkg::afr_res_t res;

    // The output register can take a new result when empty or being drained
    assign out_free  = !out_valid_reg || m_tready;
    // Parse the held byte whenever its result (if any) has somewhere to go
    assign step_en   = in_valid_reg && out_free;
    // Hold at most one byte; accept when empty or while the held one advances this cycle
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 8'd255;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    afr_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .rx_byte      (in_byte_reg),
        .search_limit (limit_reg),
        .res          (res)
    );

    // Output register: load a new result, otherwise drop the taken one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step_en && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res.valid) begin
            out_tdata_reg <= {res.byte_index, res.data};
            out_tuser_reg <= res.event_res;
            out_tlast_reg <= res.is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;
    assign m_tlast  = out_tlast_reg;

    // A held byte that cannot advance stays held
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg)
        else $error("held byte lost while output stalled");

    // Verdict and timeout results carry zero data and index
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != afr_pkg::EV_DATA |-> m_tdata == 24'd0)
        else $error("non-payload result with payload bits");

    // Only verdict and timeout results end a run
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser != afr_pkg::EV_DATA)
        else $error("payload result marked last");

    // An empty input register always accepts
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

endmodule
`default_nettype wire

>>> src/afr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afr_core
// Frame parser state and next-state logic; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module afr_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step_en,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [7:0]       search_limit,
    output afr_pkg::afr_res_t     res
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [8:0]  miss_count_reg, miss_count_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] payload_count_reg, payload_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;

    logic [7:0]  sum_add;
    logic [15:0] count_inc;
    logic [8:0]  miss_inc;

    assign sum_add   = running_sum_reg + rx_byte;
    assign count_inc = payload_count_reg + 16'd1;
    assign miss_inc  = miss_count_reg + 9'd1;

    always_comb begin
        phase_next         = phase_reg;
        miss_count_next    = miss_count_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        running_sum_next   = running_sum_reg;
        res                = '0;

        unique case (phase_reg)
            PH_LEN_HI: begin
                frame_length_next = {rx_byte, 8'h00};
                phase_next        = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                frame_length_next  = {frame_length_reg[15:8], rx_byte};
                payload_count_next = '0;
                phase_next = ({frame_length_reg[15:8], rx_byte} == 16'd0) ?
                             PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                running_sum_next   = sum_add;
                payload_count_next = count_inc;
                if (count_inc == frame_length_reg) begin
                    phase_next = PH_CHECK;
                end
                res.valid      = 1'b1;
                res.event_res  = afr_pkg::EV_DATA;
                res.data       = rx_byte;
                res.byte_index = payload_count_reg;
            end
            PH_CHECK: begin
                running_sum_next = sum_add;
                phase_next       = PH_HUNT;
                miss_count_next  = '0;
                res.valid        = 1'b1;
                res.event_res    = (sum_add == afr_pkg::SUM_OK) ?
                                   afr_pkg::EV_GOOD : afr_pkg::EV_BAD;
                res.is_last      = 1'b1;
            end
            default: begin
                if (rx_byte == afr_pkg::DELIM) begin
                    phase_next         = PH_LEN_HI;
                    miss_count_next    = '0;
                    running_sum_next   = '0;
                    frame_length_next  = '0;
                    payload_count_next = '0;
                end else begin
                    phase_next = PH_HUNT;
                    if (miss_inc > {1'b0, search_limit}) begin
                        miss_count_next = '0;
                        res.valid       = 1'b1;
                        res.event_res   = afr_pkg::EV_TIMEOUT;
                        res.is_last     = 1'b1;
                    end else begin
                        miss_count_next = miss_inc;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HUNT;
            miss_count_reg    <= '0;
            frame_length_reg  <= '0;
            payload_count_reg <= '0;
            running_sum_reg   <= '0;
        end else if (step_en) begin
            phase_reg         <= phase_next;
            miss_count_reg    <= miss_count_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
            running_sum_reg   <= running_sum_next;
        end
    end

    // Miss count is cleared as soon as it passes the limit
    a_miss_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        miss_count_reg <= 9'd255)
        else $error("miss count beyond limit range");

    // A payload phase always has a non-zero length still outstanding
    a_payload_len: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> frame_length_reg != 16'd0)
        else $error("payload phase with zero length");

    // Payload results carry no end marker
    a_data_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.event_res == afr_pkg::EV_DATA |-> !res.is_last)
        else $error("payload result marked last");

endmodule
`default_nettype wire
